[src/trainer_frame_stuffing_encoder_core_assert.svh]
// assertion macros used by the checker file
// each macro expects clk and rst to be visible where it is used
`ifndef TRAINER_FRAME_STUFFING_ENCODER_CORE_ASSERT_SVH
`define TRAINER_FRAME_STUFFING_ENCODER_CORE_ASSERT_SVH

// same-cycle implication
`define TFSE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tfse assertion failed");

// next-cycle implication
`define TFSE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tfse assertion failed");

`endif

[src/tfse_pkg.sv]
// ----------------------------------------------------------------------------
// tfse_pkg
// types and constants of the byte-stuffed trainer frame encoder
// ----------------------------------------------------------------------------
`default_nettype none

package tfse_pkg;

  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE  = 8'h7D;
  localparam logic [7:0] ESC_XOR   = 8'h20;
  localparam logic [7:0] TYPE_BYTE = 8'h80;

  localparam int VALUE_W = 12;
  localparam int RUN_LEN = 10;                       // longest byte run of one item
  localparam int RUN_CNT_W = $clog2(RUN_LEN + 1);

  typedef logic [RUN_CNT_W-1:0] run_cnt_t;

  typedef struct packed {
    logic [VALUE_W-1:0] first_value;
    logic [VALUE_W-1:0] second_value;
    logic               frame_start;
    logic               frame_end;
  } tfse_item_t;

  typedef struct packed {
    logic [RUN_LEN-1:0][7:0] bytes;   // entry 0 goes out first
    run_cnt_t                count;
    logic                    closes;  // run ends with the closing flag
  } tfse_run_t;

endpackage

`default_nettype wire

[src/tfse_encode.sv]
// ----------------------------------------------------------------------------
// tfse_encode
// packs one channel pair into bytes, stuffs them and frames the run
// ----------------------------------------------------------------------------
`default_nettype none

module tfse_encode import tfse_pkg::*; (
  input  tfse_item_t  item,
  input  logic [7:0]  checksum,
  output tfse_run_t   run,
  output logic [7:0]  checksum_next
);

  logic [2:0][7:0] data_bytes;
  logic [7:0]      cs;
  run_cnt_t        pos;

  assign data_bytes[0] = item.first_value[7:0];
  assign data_bytes[1] = {item.first_value[11:8], item.second_value[7:4]};
  assign data_bytes[2] = {item.second_value[3:0], item.second_value[11:8]};

  always_comb begin
    run = '0;
    pos = '0;
    cs  = checksum;

    // frame opening: raw flag, then the type byte which enters the checksum
    if (item.frame_start) begin
      cs = TYPE_BYTE;
      run.bytes[pos] = FLAG_BYTE;
      pos = pos + run_cnt_t'(1);
      run.bytes[pos] = TYPE_BYTE;
      pos = pos + run_cnt_t'(1);
    end

    for (int k = 0; k < 3; k++) begin
      cs = cs ^ data_bytes[k];
      if (data_bytes[k] == FLAG_BYTE || data_bytes[k] == ESC_BYTE) begin
        run.bytes[pos] = ESC_BYTE;
        pos = pos + run_cnt_t'(1);
        run.bytes[pos] = data_bytes[k] ^ ESC_XOR;
      end else begin
        run.bytes[pos] = data_bytes[k];
      end
      pos = pos + run_cnt_t'(1);
    end

    // frame closing: raw checksum, then the flag
    if (item.frame_end) begin
      run.bytes[pos] = cs;
      pos = pos + run_cnt_t'(1);
      run.bytes[pos] = FLAG_BYTE;
      pos = pos + run_cnt_t'(1);
    end

    run.count     = pos;
    run.closes    = item.frame_end;
    checksum_next = cs;
  end

endmodule

`default_nettype wire

[src/tfse_serializer.sv]
// ----------------------------------------------------------------------------
// tfse_serializer
// holds one encoded run and sends it one byte per transaction
// ----------------------------------------------------------------------------
`default_nettype none

module tfse_serializer import tfse_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  tfse_run_t  run,
  output logic       can_load,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       last_of_run,
  output logic       frame_done
);

  logic [RUN_LEN-1:0][7:0] held;
  run_cnt_t                remaining;
  logic                    closes;
  logic                    last;

  assign last        = (remaining == run_cnt_t'(1));
  assign out_valid   = (remaining != '0);
  assign out_byte    = held[0];
  assign last_of_run = last;
  assign frame_done  = last && closes;
  assign can_load    = (remaining == '0) || (last && out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
      closes    <= 1'b0;
    end else if (load) begin
      remaining <= run.count;
      closes    <= run.closes;
    end else if (out_valid && out_ready) begin
      remaining <= remaining - run_cnt_t'(1);
    end
  end

  // byte shift line, no reset needed
  always_ff @(posedge clk) begin
    if (load) begin
      held <= run.bytes;
    end else if (out_valid && out_ready) begin
      held <= {8'h00, held[RUN_LEN-1:1]};
    end
  end

endmodule

`default_nettype wire

[src/trainer_frame_stuffing_encoder_core.sv]
// an accepted pair moves from the input register into the serializer before its first byte shows
// throughput: one output byte per cycle while out_ready is high; a pair
//   gives 3 to 10 bytes (3 data bytes, one more per escape, 2 per frame edge)
// the input register takes the next pair while the serializer drains a run
// reset (synchronous, active high) empties both stages and clears the checksum
// ----------------------------------------------------------------------------
// trainer_frame_stuffing_encoder_core
// byte-stuffed frame encoder for 12-bit trainer channel pairs
// ----------------------------------------------------------------------------
`default_nettype none

module trainer_frame_stuffing_encoder_core import tfse_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [VALUE_W-1:0] first_value,
  input  wire logic [VALUE_W-1:0] second_value,
  input  wire logic               frame_start,
  input  wire logic               frame_end,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [7:0]              out_byte,
  output logic                    last_of_run,
  output logic                    frame_done
);

  // input register stage
  tfse_item_t item;
  logic       item_full;

  // running checksum, updated as each pair moves into the serializer
  logic [7:0] checksum;
  logic [7:0] checksum_next;

  tfse_run_t  run;
  logic       can_load;
  logic       load;

  assign load     = item_full && can_load;
  // free slot, or the held pair leaves in this same cycle
  assign in_ready = !item_full || can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      item_full <= 1'b1;
    end else if (load) begin
      item_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.first_value  <= first_value;
      item.second_value <= second_value;
      item.frame_start  <= frame_start;
      item.frame_end    <= frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      checksum <= '0;
    end else if (load) begin
      checksum <= checksum_next;
    end
  end

  // pack, stuff and frame the held pair
  tfse_encode u_encode (
    .item          (item),
    .checksum      (checksum),
    .run           (run),
    .checksum_next (checksum_next)
  );

  // one byte per output transaction
  tfse_serializer u_serializer (
    .clk         (clk),
    .rst         (rst),
    .load        (load),
    .run         (run),
    .can_load    (can_load),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .frame_done  (frame_done)
  );

endmodule

`default_nettype wire

[src/tfse_checker.sv]
// ----------------------------------------------------------------------------
// tfse_checker
// port-level checks of the frame encoder, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "trainer_frame_stuffing_encoder_core_assert.svh"

module tfse_checker import tfse_pkg::*; (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic [VALUE_W-1:0] first_value,
  input wire logic [VALUE_W-1:0] second_value,
  input wire logic               frame_start,
  input wire logic               frame_end,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [7:0]         out_byte,
  input wire logic               last_of_run,
  input wire logic               frame_done
);

  // closing flag is always the final byte of its run
  `TFSE_ASSERT_NOW(a_done_is_last, out_valid && frame_done, last_of_run)

  // closing flag carries the flag value
  `TFSE_ASSERT_NOW(a_done_is_flag, out_valid && frame_done, out_byte == FLAG_BYTE)

  // an escape inside a run is followed by a stuffed byte, or by the flag after a raw checksum
  `TFSE_ASSERT_NEXT(a_escape_follow,
    out_valid && out_ready && out_byte == ESC_BYTE && !last_of_run,
    out_valid && (out_byte == (FLAG_BYTE ^ ESC_XOR) || out_byte == (ESC_BYTE ^ ESC_XOR) ||
      out_byte == FLAG_BYTE))

  // stalled output transaction holds
  `TFSE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_byte) && $stable(last_of_run) && $stable(frame_done))

  // stalled input transaction holds
  `TFSE_ASSERT_NEXT(a_in_hold, in_valid && !in_ready,
    in_valid && $stable(first_value) && $stable(second_value) &&
      $stable(frame_start) && $stable(frame_end))

endmodule

bind trainer_frame_stuffing_encoder_core tfse_checker u_tfse_checker (.*);

`default_nettype wire
